// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top level of the cluster chain walker.
// Define SYNTH to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check that prop holds at every clock edge outside reset.
`define FCW_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: %m");
// Check that cond never holds at a clock edge outside reset.
`define FCW_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition: %m");
`else
`define FCW_ASSERT(label, clk, rst, prop)
`define FCW_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

// ----- hw/rtl/fcw_pkg.sv -----
// Shared constants and types of the cluster chain walker.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package fcw_pkg;

   // allocation table geometry
   localparam int TABLE_BYTES = 8192;
   localparam int TBL_AW      = $clog2(TABLE_BYTES);
   localparam logic [13:0] TBL_LIMIT = 14'(TABLE_BYTES);

   // command codes on req_cmd
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_ADV   = 2'd2;

   // cluster number limits
   localparam logic [11:0] FIRST_CLUSTER = 12'd2;
   localparam logic [11:0] END_MARK      = 12'hFF8;

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] REG_DATA_START = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_SPC        = 1'b1;

   // reset values of the configuration registers
   localparam logic [15:0] DATA_START_RST = 16'd33;
   localparam logic [7:0]  SPC_RST        = 8'd1;

   // controller to datapath commands
   typedef struct packed {
      logic load_we;     // write one table byte
      logic start_set;   // set the current cluster
      logic adv_issue;   // read table word, form product
      logic adv_finish;  // load the result register, step the chain
   } fcw_cmd_type;

endpackage

// ----- hw/rtl/fcw_ctrl.sv -----
// Controller of the cluster chain walker: input handshake, advance sequencing
// and the result valid flag. Depends on fcw_pkg.
`timescale 1ns / 1ps

module fcw_ctrl
   import fcw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output fcw_cmd_type dp_cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;
   logic out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // command decode of an accepted beat
   always_comb begin
      dp_cmd = '0;
      unique case (req_cmd)
         CMD_LOAD:  dp_cmd.load_we   = accept;
         CMD_START: dp_cmd.start_set = accept;
         CMD_ADV:   dp_cmd.adv_issue = accept;
         default:   ;
      endcase
      dp_cmd.adv_finish = (state_ff == ST_READ) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (dp_cmd.adv_issue) state_in = ST_READ;
         ST_READ: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // hold the result until taken, raise it on finish
   always_comb begin
      if (dp_cmd.adv_finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- hw/rtl/fcw_datapath.sv -----
// Datapath of the cluster chain walker: table memory, configuration,
// current cluster, sector arithmetic and result register. Depends on fcw_pkg.
`timescale 1ns / 1ps

module fcw_datapath
   import fcw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  fcw_cmd_type           dp_cmd,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [12:0]           req_table_index,
   input  logic [7:0]            req_table_byte,
   input  logic [11:0]           req_start_cluster,
   output logic [19:0]           rsp_sector_lba,
   output logic [11:0]           rsp_this_cluster,
   output logic [11:0]           rsp_next_cluster,
   output logic                  rsp_chain_end,
   output logic                  rsp_bad_cluster
);

   logic [7:0] table_mem [TABLE_BYTES];

   logic [15:0] data_start_ff;
   logic [7:0]  spc_ff;
   logic [11:0] cur_cluster_ff;

   logic [7:0]  rd_lo_ff, rd_hi_ff;
   logic        lo_ok_ff, hi_ok_ff;
   logic [19:0] prod_ff;
   logic        bad_ff, odd_ff;

   logic [19:0] lba_ff;
   logic [11:0] this_ff, next_ff;
   logic        end_ff, badout_ff;

   logic [13:0] triple;
   logic [12:0] addr_lo;
   logic [13:0] addr_hi;
   logic [11:0] diff;
   logic        cur_bad;
   logic [15:0] word;
   logic [11:0] next_val;
   logic [19:0] lba_val;

   // byte offset of the entry: cluster * 3 / 2
   assign triple  = {1'b0, cur_cluster_ff, 1'b0} + {2'b00, cur_cluster_ff};
   assign addr_lo = triple[13:1];
   assign addr_hi = {1'b0, addr_lo} + 14'd1;
   assign diff    = cur_cluster_ff - FIRST_CLUSTER;
   assign cur_bad = (cur_cluster_ff < FIRST_CLUSTER) || (cur_cluster_ff >= END_MARK);

   // table memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (dp_cmd.load_we && ({1'b0, req_table_index} < TBL_LIMIT)) begin
         table_mem[req_table_index[TBL_AW-1:0]] <= req_table_byte;
      end
      if (dp_cmd.adv_issue) begin
         rd_lo_ff <= table_mem[addr_lo[TBL_AW-1:0]];
         rd_hi_ff <= table_mem[addr_hi[TBL_AW-1:0]];
      end
   end

   // first half of an advance: flags and the cluster offset product
   always_ff @(posedge clock) begin
      if (dp_cmd.adv_issue) begin
         lo_ok_ff <= ({1'b0, addr_lo} < TBL_LIMIT);
         hi_ok_ff <= (addr_hi < TBL_LIMIT);
         prod_ff  <= {8'd0, diff} * {12'd0, spc_ff};
         bad_ff   <= cur_bad;
         odd_ff   <= cur_cluster_ff[0];
      end
   end

   assign word     = {(hi_ok_ff ? rd_hi_ff : 8'd0), (lo_ok_ff ? rd_lo_ff : 8'd0)};
   assign next_val = odd_ff ? word[15:4] : word[11:0];
   assign lba_val  = {4'd0, data_start_ff} + prod_ff;

   // result register
   always_ff @(posedge clock) begin
      if (dp_cmd.adv_finish) begin
         this_ff   <= cur_cluster_ff;
         badout_ff <= bad_ff;
         if (bad_ff) begin
            lba_ff  <= '0;
            next_ff <= '0;
            end_ff  <= 1'b0;
         end else begin
            lba_ff  <= lba_val;
            next_ff <= next_val;
            end_ff  <= (next_val >= END_MARK);
         end
      end
   end

   // configuration and chain state
   always_ff @(posedge clock) begin
      if (reset) begin
         data_start_ff  <= DATA_START_RST;
         spc_ff         <= SPC_RST;
         cur_cluster_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_DATA_START: data_start_ff <= csr_wdata;
               REG_SPC:        spc_ff        <= csr_wdata[7:0];
               default:        ;
            endcase
         end
         if (dp_cmd.start_set) begin
            cur_cluster_ff <= req_start_cluster;
         end else if (dp_cmd.adv_finish && !bad_ff) begin
            cur_cluster_ff <= next_val;
         end
      end
   end

   assign rsp_sector_lba   = lba_ff;
   assign rsp_this_cluster = this_ff;
   assign rsp_next_cluster = next_ff;
   assign rsp_chain_end    = end_ff;
   assign rsp_bad_cluster  = badout_ff;

endmodule

// ----- hw/rtl/fat12_cluster_chain_walker_unit.sv -----
// FAT12 cluster chain walker, top level. Load and start beats act at the edge on
// which they are accepted. Advance: table bytes and product are registered first,
// then the result register loads once free, so an unread result stalls it; no
// new beat is taken until it finishes. Synchronous active-high reset clears the
// chain state to cluster 0 and restores data start 33, one sector per cluster;
// the table memory is not cleared. Depends on fcw_pkg, fcw_ctrl, fcw_datapath.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fat12_cluster_chain_walker_unit
   import fcw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // configuration write port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_cmd,
   input  logic [12:0]           req_table_index,
   input  logic [7:0]            req_table_byte,
   input  logic [11:0]           req_start_cluster,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [19:0]           rsp_sector_lba,
   output logic [11:0]           rsp_this_cluster,
   output logic [11:0]           rsp_next_cluster,
   output logic                  rsp_chain_end,
   output logic                  rsp_bad_cluster
);

   // commands from the controller; the datapath reports nothing back
   fcw_cmd_type dp_cmd;

   // Controller: takes a beat whenever it is idle. An advance parks it in
   // the read state until the result register is free, then finishes.
   fcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_cmd    (dp_cmd)
   );

   // Datapath: table bytes, current cluster, sector math. The issue step of an
   // advance reads both entry bytes and forms (cluster-2)*spc; the finish step adds
   // the data start and selects the 12-bit entry.
   fcw_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .dp_cmd            (dp_cmd),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_table_index   (req_table_index),
      .req_table_byte    (req_table_byte),
      .req_start_cluster (req_start_cluster),
      .rsp_sector_lba    (rsp_sector_lba),
      .rsp_this_cluster  (rsp_this_cluster),
      .rsp_next_cluster  (rsp_next_cluster),
      .rsp_chain_end     (rsp_chain_end),
      .rsp_bad_cluster   (rsp_bad_cluster)
   );

   // an accepted advance blocks the beat after it
   `FCW_ASSERT(a_adv_blocks, clock, reset, (req_valid && req_ready && req_cmd == CMD_ADV) |=> !req_ready)
   // a good result belongs to a cluster inside the data area
   `FCW_ASSERT(a_good_range, clock, reset, (rsp_valid && !rsp_bad_cluster) |-> (rsp_this_cluster >= FIRST_CLUSTER && rsp_this_cluster < END_MARK))
   // a bad result carries no sector, entry or end flag
   `FCW_ASSERT(a_bad_empty, clock, reset, (rsp_valid && rsp_bad_cluster) |-> (rsp_sector_lba == '0 && rsp_next_cluster == '0 && !rsp_chain_end))
   // end of chain matches the entry read
   `FCW_ASSERT_NEVER(a_end_flag, clock, reset, rsp_valid && !rsp_bad_cluster && (rsp_chain_end != (rsp_next_cluster >= END_MARK)))

endmodule
